### rtl/core/csvx_pkg.sv
// csvx_pkg: shared constants and types for the csv two-field extractor
// no dependencies; used by csv_two_field_extractor, csvx_line_checker and tb

package csvx_pkg;

  // longest code kept per field
  localparam int MAX_CODE_LEN = 3;
  localparam int CODE_W       = 8 * MAX_CODE_LEN;
  // field length counts up to MAX_CODE_LEN + 1 and sticks there
  localparam int FLEN_W       = $clog2(MAX_CODE_LEN + 2);
  localparam int LEN_W        = $clog2(MAX_CODE_LEN + 1);
  localparam int COUNT_W      = 8;
  localparam int COL_W        = 8;

  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_N     = 8'h4E;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [COL_W-1:0] ORIGIN_COL_RESET = 8'd17;
  localparam logic [COL_W-1:0] DEST_COL_RESET   = 8'd18;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_ORIGIN_COL = 1'b0,
    REG_DEST_COL   = 1'b1
  } cfg_reg_t;

  // per-line verdict while scanning
  typedef enum logic [1:0] {
    VERDICT_OK       = 2'd0,
    VERDICT_INVALID  = 2'd1,
    VERDICT_TOO_LONG = 2'd2,
    VERDICT_STOPPED  = 2'd3
  } verdict_t;

  // status reported with each line result
  typedef enum logic [1:0] {
    STATUS_VALID    = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_TOO_LONG = 2'd2
  } line_status_t;

  // "NA" left-aligned in a code word
  function automatic logic [CODE_W-1:0] na_code();
    logic [CODE_W-1:0] v;
    v = '0;
    v[CODE_W-1 -: 8] = CHAR_N;
    v[CODE_W-9 -: 8] = CHAR_A;
    return v;
  endfunction

endpackage

### rtl/core/csv_two_field_extractor.sv
// csv_two_field_extractor: top level, byte scanner with a registered result
// depends on csvx_pkg

// Takes one text line as a stream of bytes, one byte per request on the s_
// side, with s_tlast on the line's last byte. Commas are counted (saturating
// at 255); the field that ends at comma number origin_column becomes the
// origin code and the one ending at destination_column the destination code,
// each up to three characters, first character in the top byte. The last
// byte of a line is scanned like any other, then one result request leaves
// on the m_ side with both codes, their lengths and a status: valid, invalid
// (empty field, field equal to "NA", or field not reached), or too long.
// A status other than valid carries zero codes and lengths. Once a line goes
// bad, or a zero byte is seen, the remaining bytes up to s_tlast are only
// counted as consumed. Rate: one byte per clock, sustained; each byte goes
// through a single compare/count step into the line state; the result lands
// in one output register in the cycle after its last byte. Input is held off
// only while that register is full and m_tready is low. The user must write the
// column registers via cfg_we/cfg_index/cfg_data while idle; it is not enforced.

module csv_two_field_extractor (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // byte stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] text_byte
  input  logic        s_tlast,    // line_end
  // line results out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,    // [23:0] origin_code, [25:24] origin_length,
                                  // [49:26] destination_code,
                                  // [51:50] destination_length, [55:52] zero
  output logic [1:0]  m_tuser     // [1:0] line_status
);

  localparam int CW = csvx_pkg::CODE_W;
  localparam int FW = csvx_pkg::FLEN_W;
  localparam int LW = csvx_pkg::LEN_W;
  localparam int NW = csvx_pkg::COUNT_W;

  // column registers
  logic [csvx_pkg::COL_W-1:0] origin_column;
  logic [csvx_pkg::COL_W-1:0] destination_column;

  // per-line scan state
  logic [NW-1:0]         comma_count, comma_count_next;
  logic [FW-1:0]         field_length, field_length_next;
  logic [CW-1:0]         field_buffer, field_buffer_next;
  logic [CW-1:0]         origin_held, origin_held_next;
  logic [LW-1:0]         origin_len_held, origin_len_held_next;
  logic [CW-1:0]         destination_held, destination_held_next;
  logic [LW-1:0]         destination_len_held, destination_len_held_next;
  logic [1:0]            fields_found, fields_found_next;
  csvx_pkg::verdict_t    line_verdict, line_verdict_next;

  // output register
  logic [CW-1:0]          out_origin, out_dest;
  logic [LW-1:0]          out_origin_len, out_dest_len;
  csvx_pkg::line_status_t out_status;

  logic                   in_accept;
  logic [NW-1:0]          count_inc;
  logic                   is_o, is_d;
  logic [2:0]             found_sum;
  csvx_pkg::line_status_t res_status;

  // a new byte may enter whenever the output slot is free or being drained
  assign s_tready  = !m_tvalid || m_tready;
  assign in_accept = s_tvalid && s_tready;

  assign count_inc = comma_count + NW'(1);
  assign is_o      = (count_inc == origin_column);
  assign is_d      = (count_inc == destination_column);
  assign found_sum = {1'b0, fields_found} + {2'b00, is_o} + {2'b00, is_d};

  // scan one byte into the line state
  always_comb begin
    comma_count_next          = comma_count;
    field_length_next         = field_length;
    field_buffer_next         = field_buffer;
    origin_held_next          = origin_held;
    origin_len_held_next      = origin_len_held;
    destination_held_next     = destination_held;
    destination_len_held_next = destination_len_held;
    fields_found_next         = fields_found;
    line_verdict_next         = line_verdict;

    if (in_accept && line_verdict == csvx_pkg::VERDICT_OK) begin
      if (s_tdata == csvx_pkg::CHAR_NUL) begin
        // zero byte ends the scan like a string terminator
        line_verdict_next = csvx_pkg::VERDICT_STOPPED;
      end else if (s_tdata == csvx_pkg::CHAR_COMMA) begin
        if (comma_count != csvx_pkg::COUNT_MAX) begin
          comma_count_next = count_inc;
          if (is_o || is_d) begin
            // close a chosen field
            priority if (field_length == '0) begin
              line_verdict_next = csvx_pkg::VERDICT_INVALID;
            end else if (field_length > FW'(csvx_pkg::MAX_CODE_LEN)) begin
              line_verdict_next = csvx_pkg::VERDICT_TOO_LONG;
            end else if (field_length == FW'(2) &&
                         field_buffer == csvx_pkg::na_code()) begin
              line_verdict_next = csvx_pkg::VERDICT_INVALID;
            end else begin
              if (is_o) begin
                origin_held_next     = field_buffer;
                origin_len_held_next = field_length[LW-1:0];
              end
              if (is_d) begin
                destination_held_next     = field_buffer;
                destination_len_held_next = field_length[LW-1:0];
              end
              fields_found_next = (found_sum > 3'd3) ? 2'd3 : found_sum[1:0];
            end
          end
        end
        field_length_next = '0;
        field_buffer_next = '0;
      end else begin
        // ordinary character: keep the first few, count one past the limit
        if (field_length < FW'(csvx_pkg::MAX_CODE_LEN)) begin
          for (int i = 0; i < csvx_pkg::MAX_CODE_LEN; i++) begin
            if (field_length == FW'(csvx_pkg::MAX_CODE_LEN - 1 - i)) begin
              field_buffer_next[i*8 +: 8] = s_tdata;
            end
          end
          field_length_next = field_length + FW'(1);
        end else if (field_length == FW'(csvx_pkg::MAX_CODE_LEN)) begin
          field_length_next = field_length + FW'(1);
        end
      end
    end
  end

  // line status from the state after the last byte
  always_comb begin
    unique case (line_verdict_next)
      csvx_pkg::VERDICT_INVALID:  res_status = csvx_pkg::STATUS_INVALID;
      csvx_pkg::VERDICT_TOO_LONG: res_status = csvx_pkg::STATUS_TOO_LONG;
      default: res_status = (fields_found_next == 2'd2) ? csvx_pkg::STATUS_VALID
                                                        : csvx_pkg::STATUS_INVALID;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_column      <= csvx_pkg::ORIGIN_COL_RESET;
      destination_column <= csvx_pkg::DEST_COL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csvx_pkg::REG_ORIGIN_COL: origin_column      <= cfg_data;
        csvx_pkg::REG_DEST_COL:   destination_column <= cfg_data;
        default: ;
      endcase
    end
  end

  // line state; the last byte of a line clears it for the next one
  always_ff @(posedge clk) begin
    if (rst || (in_accept && s_tlast)) begin
      comma_count          <= '0;
      field_length         <= '0;
      field_buffer         <= '0;
      origin_held          <= '0;
      origin_len_held      <= '0;
      destination_held     <= '0;
      destination_len_held <= '0;
      fields_found         <= '0;
      line_verdict         <= csvx_pkg::VERDICT_OK;
    end else begin
      comma_count          <= comma_count_next;
      field_length         <= field_length_next;
      field_buffer         <= field_buffer_next;
      origin_held          <= origin_held_next;
      origin_len_held      <= origin_len_held_next;
      destination_held     <= destination_held_next;
      destination_len_held <= destination_len_held_next;
      fields_found         <= fields_found_next;
      line_verdict         <= line_verdict_next;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_accept && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output payload; codes are zeroed unless the line is valid
  always_ff @(posedge clk) begin
    if (in_accept && s_tlast) begin
      out_status <= res_status;
      if (res_status == csvx_pkg::STATUS_VALID) begin
        out_origin     <= origin_held_next;
        out_origin_len <= origin_len_held_next;
        out_dest       <= destination_held_next;
        out_dest_len   <= destination_len_held_next;
      end else begin
        out_origin     <= '0;
        out_origin_len <= '0;
        out_dest       <= '0;
        out_dest_len   <= '0;
      end
    end
  end

  assign m_tdata = {4'b0000, out_dest_len, out_dest, out_origin_len, out_origin};
  assign m_tuser = out_status;

`ifndef SYNTHESIS
  // a finished line always produces a result next cycle
  a_line_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_accept && s_tlast |=> m_tvalid)
    else $error("line end did not produce a result");

  // line state is clear after a line end
  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    in_accept && s_tlast |=> comma_count == '0 && fields_found == 2'd0 &&
                             line_verdict == csvx_pkg::VERDICT_OK)
    else $error("line state not cleared after line end");

  // a bad line carries no codes
  a_bad_line_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != csvx_pkg::STATUS_VALID |-> m_tdata == '0)
    else $error("non-valid result carries code data");

  // a valid line has both codes non-empty
  a_valid_lengths: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == csvx_pkg::STATUS_VALID |->
      m_tdata[25:24] != 2'd0 && m_tdata[51:50] != 2'd0)
    else $error("valid result with empty code");

  // status code three is never reported
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser != 2'd3)
    else $error("undefined line status");
`endif

endmodule

### dv/csvx_line_checker.sv
`timescale 1ns / 1ps
// csvx_line_checker: watches the byte, result and configuration channels of the
// csv two-field extractor, predicts each line result and compares it
// depends on csvx_pkg

module csvx_line_checker
  import csvx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] text_byte
  input  logic        s_tlast,    // line_end
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,    // [23:0] origin_code, [25:24] origin_length,
                                  // [49:26] destination_code,
                                  // [51:50] destination_length, [55:52] zero
  input  logic [1:0]  m_tuser,    // [1:0] line_status
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [CODE_W-1:0] org;
    logic [LEN_W-1:0]  org_len;
    logic [CODE_W-1:0] dst;
    logic [LEN_W-1:0]  dst_len;
    line_status_t      status;
  } line_result_t;

  line_result_t line_results_due[$];

  logic [COL_W-1:0]   origin_col;
  logic [COL_W-1:0]   dest_col;

  logic [COUNT_W-1:0] commas_seen;
  logic [FLEN_W-1:0]  cur_len;
  logic [CODE_W-1:0]  cur_chars;
  logic [CODE_W-1:0]  org_chars;
  logic [LEN_W-1:0]   org_len;
  logic [CODE_W-1:0]  dst_chars;
  logic [LEN_W-1:0]   dst_len;
  logic [1:0]         captured;
  verdict_t           verdict;

  task clear_line();
    commas_seen = '0;
    cur_len     = '0;
    cur_chars   = '0;
    org_chars   = '0;
    org_len     = '0;
    dst_chars   = '0;
    dst_len     = '0;
    captured    = '0;
    verdict     = VERDICT_OK;
  endtask

  // field ended by a comma that matches one or both columns
  task close_field(input logic hit_o, input logic hit_d);
    if (cur_len == 0) begin
      verdict = VERDICT_INVALID;
    end else if (cur_len > MAX_CODE_LEN) begin
      verdict = VERDICT_TOO_LONG;
    end else if (cur_len == 2 && cur_chars == {CHAR_N, CHAR_A, {(CODE_W-16){1'b0}}}) begin
      verdict = VERDICT_INVALID;
    end else begin
      if (hit_o) begin
        org_chars = cur_chars;
        org_len   = cur_len[LEN_W-1:0];
        if (captured != 2'd3) captured = captured + 2'd1;
      end
      if (hit_d) begin
        dst_chars = cur_chars;
        dst_len   = cur_len[LEN_W-1:0];
        if (captured != 2'd3) captured = captured + 2'd1;
      end
    end
  endtask

  task scan_byte(input logic [7:0] c);
    logic hit_o;
    logic hit_d;
    // bad or stopped lines ignore the rest of their bytes
    if (verdict == VERDICT_OK) begin
      if (c == CHAR_NUL) begin
        verdict = VERDICT_STOPPED;
      end else if (c == CHAR_COMMA) begin
        // saturated count matches no column
        if (commas_seen != COUNT_MAX) begin
          commas_seen = commas_seen + COUNT_W'(1);
          hit_o = (commas_seen == origin_col);
          hit_d = (commas_seen == dest_col);
          if (hit_o || hit_d) close_field(hit_o, hit_d);
        end
        cur_len   = '0;
        cur_chars = '0;
      end else if (cur_len < MAX_CODE_LEN) begin
        cur_chars[CODE_W-1-8*cur_len -: 8] = c;
        cur_len = cur_len + FLEN_W'(1);
      end else if (cur_len == MAX_CODE_LEN) begin
        cur_len = cur_len + FLEN_W'(1);
      end
    end
  endtask

  task close_line();
    line_result_t r;
    r = '0;
    if (verdict == VERDICT_INVALID)
      r.status = STATUS_INVALID;
    else if (verdict == VERDICT_TOO_LONG)
      r.status = STATUS_TOO_LONG;
    else
      r.status = (captured == 2'd2) ? STATUS_VALID : STATUS_INVALID;
    if (r.status == STATUS_VALID) begin
      r.org     = org_chars;
      r.org_len = org_len;
      r.dst     = dst_chars;
      r.dst_len = dst_len;
    end
    line_results_due.push_back(r);
    clear_line();
  endtask

  task note_field(input string what, input logic [23:0] want, input logic [23:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, what, want, got);
      errors = errors + 1;
    end
  endtask

  task check_result();
    line_result_t want;
    if (line_results_due.size() == 0) begin
      $display("%0t: line result with none due, tdata %h tuser %h", $time, m_tdata, m_tuser);
      errors = errors + 1;
    end else begin
      want = line_results_due.pop_front();
      note_field("origin_code", want.org, m_tdata[23:0]);
      note_field("origin_length", 24'(want.org_len), 24'(m_tdata[25:24]));
      note_field("destination_code", want.dst, m_tdata[49:26]);
      note_field("destination_length", 24'(want.dst_len), 24'(m_tdata[51:50]));
      note_field("tdata padding", 24'(0), 24'(m_tdata[55:52]));
      note_field("line_status", 24'(want.status), 24'(m_tuser));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      origin_col = ORIGIN_COL_RESET;
      dest_col   = DEST_COL_RESET;
      clear_line();
      line_results_due.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ORIGIN_COL: origin_col = cfg_data;
          REG_DEST_COL:   dest_col   = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) check_result();
      if (s_tvalid && s_tready) begin
        scan_byte(s_tdata);
        if (s_tlast) close_line();
      end
    end
    pending = line_results_due.size();
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// tb: top of the csv two-field extractor bench, drives text lines and column
// settings; depends on csvx_pkg, csv_two_field_extractor and csvx_line_checker

module tb;
  import csvx_pkg::*;

  // generous bound, far above the slowest legal run
  localparam int CYCLE_LIMIT = 400000;
  // random part stops once about this many bytes went in
  localparam int BYTE_TARGET = 1400;
  localparam int HOLD_CYCLES = 300;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [0:0]  cfg_index = REG_ORIGIN_COL;
  logic [7:0]  cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;    // [7:0] text_byte
  logic        s_tlast   = 1'b0;  // line_end
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [55:0] m_tdata;           // [23:0] origin_code, [25:24] origin_length,
                                  // [49:26] destination_code,
                                  // [51:50] destination_length, [55:52] zero
  logic [1:0]  m_tuser;           // [1:0] line_status

  int errors;
  int pending;

  int cycles     = 0;
  int bytes_sent = 0;
  int burst_left = 0;
  bit hold_req   = 1'b0;

  // bytes of the line under construction, line_end goes on the final one
  logic [7:0] line_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  csv_two_field_extractor uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  csvx_line_checker line_chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .errors    (errors),
    .pending   (pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: stall patterns of its own, plus one long hold-off so the
  // output register fills and the byte side backs up
  initial begin : result_sink
    int         hold_left;
    int         pat_left;
    int         mode;
    bit         hold_done;
    logic [31:0] pat;
    hold_left = 0;
    pat_left  = 0;
    mode      = 0;
    hold_done = 1'b0;
    pat       = '1;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_tready  <= 1'b0;
        hold_left = hold_left - 1;
      end else if (hold_req && !hold_done) begin
        m_tready  <= 1'b0;
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        if (pat_left == 0) begin
          // always ready, random, mostly ready, mostly stalled
          mode     = $urandom_range(0, 3);
          pat      = $urandom;
          if (mode == 2) pat = pat | $urandom;
          if (mode == 3) pat = pat & $urandom;
          pat_left = $urandom_range(16, 80);
        end
        m_tready <= (mode == 0) ? 1'b1 : pat[0];
        pat      = {pat[0], pat[31:1]};
        pat_left = pat_left - 1;
      end
    end
  end

  // one byte request; gaps between bursts of random length
  task push_byte(input logic [7:0] b, input bit close);
    int gap;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= close;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left = burst_left - 1;
    bytes_sent = bytes_sent + 1;
  endtask

  // text bytes, line_end on the final character when close is set
  task push_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++)
      push_byte(s[i], close && (i == s.len() - 1));
  endtask

  task send_line();
    for (int i = 0; i < line_q.size(); i++)
      push_byte(line_q[i], i == line_q.size() - 1);
  endtask

  // column writes only with the block idle: every line closed, every result out
  task set_columns(input logic [7:0] ocol, input logic [7:0] dcol);
    s_tvalid <= 1'b0;
    // the checker updates its count at the edge, look after it settles
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    // extra margin once the result register has drained
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ORIGIN_COL;
    cfg_data  <= ocol;
    @(posedge clk);
    cfg_index <= REG_DEST_COL;
    cfg_data  <= dcol;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // any byte but the delimiter and the terminator, letters half the time
  function automatic logic [7:0] pick_char();
    logic [7:0] v;
    if ($urandom_range(0, 1))
      v = 8'($urandom_range(65, 90));
    else
      v = 8'($urandom_range(1, 255));
    if (v == CHAR_COMMA) v = 8'h2D;
    return v;
  endfunction

  task add_field(input bit chosen, input bit sparse);
    int k;
    int n;
    if (chosen) begin
      k = $urandom_range(0, 99);
      if (k < 8) begin
        n = 0;                                  // empty field
      end else if (k < 16) begin
        line_q.push_back(CHAR_N);               // exactly NA
        line_q.push_back(CHAR_A);
        n = 0;
      end else if (k < 22) begin
        line_q.push_back(CHAR_N);               // near miss on NA
        n = $urandom_range(1, 2);
      end else if (k < 30) begin
        n = $urandom_range(4, 6);               // too long
      end else begin
        n = $urandom_range(1, 3);
      end
    end else begin
      n = sparse ? ($urandom_range(0, 3) == 0) : $urandom_range(0, 3);
    end
    for (int i = 0; i < n; i++) line_q.push_back(pick_char());
  endtask

  // mostly well-formed lines reaching both columns, some cut short, some with
  // a terminator byte, and a few that are plain noise
  task build_line(input int ocol, input int dcol, input bit clean);
    int kind;
    int nf;
    int extra;
    int cut;
    line_q.delete();
    kind = clean ? 99 : $urandom_range(0, 99);
    if (kind < 8) begin
      cut = $urandom_range(1, 30);
      for (int i = 0; i < cut; i++) begin
        if ($urandom_range(0, 3) == 0)
          line_q.push_back(CHAR_COMMA);
        else
          line_q.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      nf    = (ocol > dcol) ? ocol : dcol;
      // very long lines go past the comma count saturation
      extra = (nf > 200) ? 3 : $urandom_range(0, 2);
      for (int f = 1; f <= nf + extra; f++) begin
        add_field((f == ocol) || (f == dcol), nf > 20);
        if (f < nf + extra || $urandom_range(0, 1)) line_q.push_back(CHAR_COMMA);
      end
      if (!clean && $urandom_range(0, 9) == 0) begin
        // line may end before a chosen field is reached
        cut = $urandom_range(1, line_q.size());
        while (line_q.size() > cut) line_q.delete(line_q.size() - 1);
      end
      if (!clean && $urandom_range(0, 14) == 0)
        line_q[$urandom_range(0, line_q.size() - 1)] = CHAR_NUL;
    end
    if (line_q.size() == 0) line_q.push_back(pick_char());
  endtask

  task run_lines(input int ocol, input int dcol, input int budget, input bit clean);
    int sent;
    sent = 0;
    while (sent < budget) begin
      build_line(ocol, dcol, clean);
      sent = sent + line_q.size();
      send_line();
    end
  endtask

  initial begin : stimulus
    int ocol;
    int dcol;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // columns straight out of reset
    run_lines(17, 18, 80, 1'b0);

    // directed lines, origin is the first field, destination the second
    set_columns(8'd1, 8'd2);
    push_text("X", 1'b0);                       // top and bottom byte values
    push_byte(8'hFF, 1'b0);
    push_text(",Q,", 1'b0);
    push_byte(CHAR_NUL, 1'b1);                  // terminator after both fields
    push_text("NA,B,", 1'b1);                   // origin is NA
    push_text(",B", 1'b1);                      // empty origin
    push_text("ABCD,", 1'b1);                   // origin too long
    push_text("A", 1'b1);                       // no comma before line end
    push_text("A,", 1'b0);
    push_byte(CHAR_NUL, 1'b0);                  // terminator before destination
    push_text("B,", 1'b1);                      // ignored after the stop

    // random part; the long hold-off lands early in it
    hold_req = 1'b1;
    run_lines(1, 2, 150, 1'b0);
    set_columns(8'd2, 8'd2);                    // one field is both codes
    run_lines(2, 2, 120, 1'b0);
    set_columns(8'd3, 8'd1);
    run_lines(3, 1, 120, 1'b0);
    set_columns(8'd0, 8'd2);                    // column zero never matches
    run_lines(0, 2, 60, 1'b0);
    set_columns(8'd2, 8'd0);
    run_lines(2, 0, 40, 1'b0);
    set_columns(8'd255, 8'd1);                  // highest column, saturating count
    run_lines(255, 1, 1, 1'b1);
    set_columns(8'd1, 8'd255);
    run_lines(1, 255, 1, 1'b1);
    while (bytes_sent < BYTE_TARGET) begin
      ocol = $urandom_range(1, 6);
      dcol = $urandom_range(1, 6);
      set_columns(8'(ocol), 8'(dcol));
      run_lines(ocol, dcol, 100, 1'b0);
    end

    // drain
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
